// File: src/aft_pkg.sv
package aft_pkg;

    // Focus state reported to the host
    typedef enum logic [1:0]
    {
        ST_IDLE     = 2'd0,
        ST_SCANNING = 2'd1,
        ST_FOCUSED  = 2'd2,
        ST_FAILED   = 2'd3
    } focus_state_t;

    // Item kinds
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_REPORT  = 1'b1;

    // Trigger codes (three acts as idle)
    localparam logic [1:0] TRIG_IDLE   = 2'd0;
    localparam logic [1:0] TRIG_START  = 2'd1;
    localparam logic [1:0] TRIG_CANCEL = 2'd2;

    // Focus mode codes (others behave as auto)
    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_AUTO  = 3'd1;
    localparam logic [2:0] MODE_CVID  = 3'd3;
    localparam logic [2:0] MODE_CPIC  = 3'd4;

    // Engine status codes (others behave as idle)
    localparam logic [2:0] ENG_LOCAL    = 3'd1;
    localparam logic [2:0] ENG_EXTENDED = 3'd2;
    localparam logic [2:0] ENG_SUCCESS  = 3'd3;
    localparam logic [2:0] ENG_FAIL     = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAX_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_MIN_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_FRAME_LIMIT = 2'd2;

    localparam int TIME_W  = 48;
    localparam int TOUT_W  = 24;
    localparam int FRAME_W = 10;

    localparam logic [TOUT_W-1:0]  MAX_TIMEOUT_RST = 24'd4000000;
    localparam logic [TOUT_W-1:0]  MIN_TIMEOUT_RST = 24'd2000000;
    localparam logic [FRAME_W-1:0] FRAME_LIMIT_RST = 10'd60;
    localparam logic [FRAME_W-1:0] FRAME_MAX       = 10'd1023;

    // Configuration registers as seen by the tracker core
    typedef struct packed
    {
        logic [TOUT_W-1:0]  max_timeout_us;
        logic [TOUT_W-1:0]  min_timeout_us;
        logic [FRAME_W-1:0] frame_limit;
    } cfg_t;

    // One input item
    typedef struct packed
    {
        logic              operation;
        logic [1:0]        trigger;
        logic [2:0]        focus_mode;
        logic [2:0]        engine_status;
        logic              lens_moving;
        logic [TIME_W-1:0] now_us;
    } item_t;

    // One result item
    typedef struct packed
    {
        logic [2:0] mode_out;
        logic [1:0] trigger_out;
        logic [1:0] focus_state;
        logic       lens_state;
    } result_t;

endpackage

// File: src/aft_core.sv
module aft_core
    import aft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output logic    has_result,
    output result_t result
);

    typedef enum logic [1:0]
    {
        BANK_OFF,
        BANK_AUTO,
        BANK_CONT
    } bank_sel_t;

    typedef struct packed
    {
        focus_state_t       state;
        logic [TIME_W-1:0]  trig_time;
        logic [FRAME_W-1:0] frames;
    } bank_t;

    bank_t      auto_reg, auto_next;
    bank_t      cont_reg, cont_next;
    logic [2:0] last_mode_reg, last_mode_next;
    logic [1:0] last_trig_reg, last_trig_next;
    bank_sel_t  req_bank, rep_bank;

    function automatic bank_sel_t bank_of(logic [2:0] mode);
        bank_sel_t b;
        case (mode) inside
            MODE_OFF:             b = BANK_OFF;
            MODE_CVID, MODE_CPIC: b = BANK_CONT;
            default:              b = BANK_AUTO;
        endcase
        return b;
    endfunction

    // Frame count and elapsed-time check applied after a report
    function automatic bank_t timeout_apply(bank_t b, logic [TIME_W-1:0] now, cfg_t c);
        bank_t             r;
        logic [TIME_W-1:0] elapsed;
        r       = b;
        elapsed = now - b.trig_time;
        if (b.trig_time != '0)
        begin
            if (r.frames != FRAME_MAX)
                r.frames = r.frames + 1'b1;
            if (r.state != ST_FOCUSED &&
                (elapsed > {{(TIME_W-TOUT_W){1'b0}}, c.max_timeout_us} ||
                 (r.frames > c.frame_limit &&
                  elapsed > {{(TIME_W-TOUT_W){1'b0}}, c.min_timeout_us})))
            begin
                r.trig_time = '0;
                r.frames    = '0;
                r.state     = ST_FAILED;
            end
        end
        return r;
    endfunction

    assign req_bank = bank_of(item.focus_mode);
    assign rep_bank = bank_of(last_mode_reg);

    // Next bank state for the item on hand
    always_comb
    begin
        auto_next      = auto_reg;
        cont_next      = cont_reg;
        last_mode_next = last_mode_reg;
        last_trig_next = last_trig_reg;
        if (item.operation == OP_REQUEST)
        begin
            last_mode_next = item.focus_mode;
            last_trig_next = item.trigger;
            if (item.focus_mode != last_mode_reg)
            begin
                if (req_bank == BANK_AUTO)
                    auto_next.state = ST_IDLE;
                else if (req_bank == BANK_CONT)
                    cont_next.state = ST_IDLE;
            end
            if (req_bank == BANK_AUTO)
            begin
                if (item.trigger == TRIG_START)
                begin
                    auto_next.trig_time = item.now_us;
                    auto_next.frames    = '0;
                    auto_next.state     = ST_SCANNING;
                end
                else if (item.trigger == TRIG_CANCEL)
                begin
                    auto_next.trig_time = '0;
                    auto_next.frames    = '0;
                    auto_next.state     = ST_IDLE;
                end
            end
            else if (req_bank == BANK_CONT)
            begin
                if (item.trigger == TRIG_START)
                begin
                    cont_next.trig_time = item.now_us;
                    cont_next.frames    = '0;
                    cont_next.state     = ST_SCANNING;
                end
                else if (item.trigger == TRIG_CANCEL)
                begin
                    cont_next.trig_time = '0;
                    cont_next.frames    = '0;
                    if (cont_next.state != ST_FOCUSED)
                        cont_next.state = ST_IDLE;
                end
            end
        end
        else if (rep_bank == BANK_AUTO)
        begin
            // auto: only an armed search reacts to the engine
            if (auto_reg.trig_time != '0)
            begin
                case (item.engine_status)
                    ENG_SUCCESS:
                    begin
                        auto_next.state     = ST_FOCUSED;
                        auto_next.trig_time = '0;
                        auto_next.frames    = '0;
                    end
                    ENG_FAIL:
                    begin
                        auto_next.state     = ST_FAILED;
                        auto_next.trig_time = '0;
                        auto_next.frames    = '0;
                    end
                    default: ;
                endcase
            end
            auto_next = timeout_apply(auto_next, item.now_us, cfg);
        end
        else if (rep_bank == BANK_CONT)
        begin
            // continuous: a settled result is kept until re-triggered
            if (cont_reg.state != ST_FOCUSED && cont_reg.state != ST_FAILED)
            begin
                case (item.engine_status)
                    ENG_LOCAL, ENG_EXTENDED:
                        cont_next.state = ST_SCANNING;
                    ENG_SUCCESS:
                    begin
                        cont_next.state     = ST_FOCUSED;
                        cont_next.trig_time = '0;
                        cont_next.frames    = '0;
                    end
                    ENG_FAIL:
                    begin
                        cont_next.state     = ST_FAILED;
                        cont_next.trig_time = '0;
                        cont_next.frames    = '0;
                    end
                    default: ;
                endcase
            end
            cont_next = timeout_apply(cont_next, item.now_us, cfg);
        end
    end

    // Result of a report
    always_comb
    begin
        has_result         = (item.operation == OP_REPORT);
        result.mode_out    = last_mode_reg;
        result.trigger_out = last_trig_reg;
        result.lens_state  = item.lens_moving;
        case (rep_bank)
            BANK_AUTO: result.focus_state = auto_next.state;
            BANK_CONT: result.focus_state = cont_next.state;
            default:   result.focus_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg      <= '{state: ST_IDLE, trig_time: '0, frames: '0};
            cont_reg      <= '{state: ST_SCANNING, trig_time: '0, frames: '0};
            last_mode_reg <= MODE_AUTO;
            last_trig_reg <= TRIG_IDLE;
        end
        else if (item_en)
        begin
            auto_reg      <= auto_next;
            cont_reg      <= cont_next;
            last_mode_reg <= last_mode_next;
            last_trig_reg <= last_trig_next;
        end
    end

endmodule

// File: src/autofocus_state_tracker_top.sv
// Autofocus state tracker. Trigger requests (tuser 0) set the focus mode and
// start or cancel a search; engine reports (tuser 1) update the focus state of
// the bank chosen by the last requested mode, apply the time and frame
// timeouts, and produce exactly one result each; requests produce none. One
// item is taken every clock cycle while the input is not stalled: an item is
// registered on entry, passes through the bank update logic, and its result
// is held in an output register. The input stalls only while a result waits
// unaccepted in the output register and the item held in the input register
// is also a report. Configuration writes are always accepted and should be
// made while no item is in flight.
module autofocus_state_tracker_top
    import aft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // trigger[1:0], focus_mode[4:2], engine_status[7:5], lens_moving[8],
    // now_us[56:9], zero fill[63:57]
    input  logic [63:0] s_axis_tdata,
    // operation[0]
    input  logic        s_axis_tuser,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // mode_out[2:0], trigger_out[4:3], focus_state[6:5], lens_state[7]
    output logic [7:0]  m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    item_t   in_item;
    logic    core_has_result;
    result_t core_result;
    logic    advance;

    // Unpack the slave-side transaction
    assign in_item.operation     = s_axis_tuser;
    assign in_item.trigger       = s_axis_tdata[1:0];
    assign in_item.focus_mode    = s_axis_tdata[4:2];
    assign in_item.engine_status = s_axis_tdata[7:5];
    assign in_item.lens_moving   = s_axis_tdata[8];
    assign in_item.now_us        = s_axis_tdata[56:9];

    // Item moves on unless its result would collide with a stalled one
    assign advance       = in_valid_reg &&
                           (!core_has_result || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    aft_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_en    (advance),
        .item       (in_item_reg),
        .cfg        (cfg_reg),
        .has_result (core_has_result),
        .result     (core_result)
    );

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_timeout_us <= MAX_TIMEOUT_RST;
            cfg_reg.min_timeout_us <= MIN_TIMEOUT_RST;
            cfg_reg.frame_limit    <= FRAME_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_TIMEOUT: cfg_reg.max_timeout_us <= cfg_data;
                CFG_MIN_TIMEOUT: cfg_reg.min_timeout_us <= cfg_data;
                CFG_FRAME_LIMIT: cfg_reg.frame_limit    <= cfg_data[FRAME_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= in_item;
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && core_has_result)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_has_result)
            out_data_reg <= core_result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_data_reg.lens_state, out_data_reg.focus_state,
                            out_data_reg.trigger_out, out_data_reg.mode_out};

endmodule

// File: src/aft_checker.sv
module aft_checker
    import aft_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result shown during reset");

    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Off mode always reports idle
    a_off_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] == MODE_OFF |-> m_axis_tdata[6:5] == ST_IDLE)
        else $error("off mode reported a focus state other than idle");

    // Input is never held off while no result is waiting
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

bind autofocus_state_tracker_top aft_checker u_aft_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/autofocus_state_tracker_top_test.sv
module autofocus_state_tracker_top_test;

    import aft_pkg::*;

    // Codes the package leaves unnamed
    localparam logic [2:0] MODE_MACRO = 3'd2;
    localparam logic [2:0] MODE_ALIAS = 3'd7;
    localparam logic [1:0] TRIG_ALIAS = 2'd3;
    localparam logic [2:0] ENG_QUIET  = 3'd0;
    localparam logic [2:0] ENG_ALIAS  = 3'd5;
    localparam logic [2:0] ENG_TOP    = 3'd7;
    localparam logic [1:0] CFG_SPARE  = 2'd3;

    typedef enum logic [1:0]
    {
        BANK_NONE,
        BANK_SINGLE,
        BANK_CONT
    } bank_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = 64'd0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [23:0] cfg_data = 24'd0;

    // Tracker state as predicted
    focus_state_t      af_state;
    focus_state_t      cf_state;
    logic [TIME_W-1:0]  af_armed_at;
    logic [TIME_W-1:0]  cf_armed_at;
    logic [FRAME_W-1:0] af_frames;
    logic [FRAME_W-1:0] cf_frames;
    logic [2:0]         cur_mode;
    logic [1:0]         cur_trig;
    logic [TOUT_W-1:0]  lim_max;
    logic [TOUT_W-1:0]  lim_min;
    logic [FRAME_W-1:0] lim_frames;

    result_t           reports_due[$];
    result_t           due;
    int                errors = 0;
    bit                idle_en = 1'b1;
    int                stall_left = 0;
    logic [TIME_W-1:0] clock_us;
    int unsigned       frame_step;

    always #5 clk = ~clk;

    autofocus_state_tracker_top i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    function automatic bank_t bank_of(input logic [2:0] mode);
        if (mode == MODE_OFF)
            return BANK_NONE;
        if (mode == MODE_CVID || mode == MODE_CPIC)
            return BANK_CONT;
        return BANK_SINGLE;
    endfunction

    // Frame count and timeout handling of an armed bank
    task automatic age_search(inout focus_state_t st, inout logic [TIME_W-1:0] t0,
                              inout logic [FRAME_W-1:0] fr, input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] elapsed;
        if (t0 != '0)
        begin
            if (fr != FRAME_MAX)
                fr = fr + 1'b1;
            elapsed = now - t0;
            if (st != ST_FOCUSED &&
                (elapsed > {24'd0, lim_max} ||
                 (fr > lim_frames && elapsed > {24'd0, lim_min})))
            begin
                t0 = '0;
                fr = '0;
                st = ST_FAILED;
            end
        end
    endtask

    // Advance the tracker prediction by one accepted item
    task automatic track_focus(input item_t it);
        bank_t        b;
        focus_state_t fs;
        result_t      r;
        if (it.operation == OP_REQUEST)
        begin
            b = bank_of(it.focus_mode);
            if (it.focus_mode != cur_mode)
            begin
                if (b == BANK_SINGLE)
                    af_state = ST_IDLE;
                else if (b == BANK_CONT)
                    cf_state = ST_IDLE;
            end
            cur_mode = it.focus_mode;
            cur_trig = it.trigger;
            if (b == BANK_SINGLE)
            begin
                if (it.trigger == TRIG_START)
                begin
                    af_armed_at = it.now_us;
                    af_frames = '0;
                    af_state = ST_SCANNING;
                end
                else if (it.trigger == TRIG_CANCEL)
                begin
                    af_armed_at = '0;
                    af_frames = '0;
                    af_state = ST_IDLE;
                end
            end
            else if (b == BANK_CONT)
            begin
                if (it.trigger == TRIG_START)
                begin
                    cf_armed_at = it.now_us;
                    cf_frames = '0;
                    cf_state = ST_SCANNING;
                end
                else if (it.trigger == TRIG_CANCEL)
                begin
                    cf_armed_at = '0;
                    cf_frames = '0;
                    if (cf_state != ST_FOCUSED)
                        cf_state = ST_IDLE;
                end
            end
        end
        else
        begin
            b = bank_of(cur_mode);
            fs = ST_IDLE;
            if (b == BANK_SINGLE)
            begin
                // engine verdicts only count while a search is armed
                if (af_armed_at != '0 &&
                    (it.engine_status == ENG_SUCCESS || it.engine_status == ENG_FAIL))
                begin
                    af_state = (it.engine_status == ENG_SUCCESS) ? ST_FOCUSED : ST_FAILED;
                    af_armed_at = '0;
                    af_frames = '0;
                end
                age_search(af_state, af_armed_at, af_frames, it.now_us);
                fs = af_state;
            end
            else if (b == BANK_CONT)
            begin
                // focused and failed are sticky until the next trigger
                if (cf_state != ST_FOCUSED && cf_state != ST_FAILED)
                begin
                    if (it.engine_status == ENG_LOCAL || it.engine_status == ENG_EXTENDED)
                        cf_state = ST_SCANNING;
                    else if (it.engine_status == ENG_SUCCESS ||
                             it.engine_status == ENG_FAIL)
                    begin
                        cf_state = (it.engine_status == ENG_SUCCESS) ? ST_FOCUSED : ST_FAILED;
                        cf_armed_at = '0;
                        cf_frames = '0;
                    end
                end
                age_search(cf_state, cf_armed_at, cf_frames, it.now_us);
                fs = cf_state;
            end
            r.mode_out = cur_mode;
            r.trigger_out = cur_trig;
            r.focus_state = fs;
            r.lens_state = it.lens_moving;
            reports_due.push_back(r);
        end
    endtask

    function automatic item_t make_request(input logic [2:0] mode, input logic [1:0] trig,
                                           input logic [TIME_W-1:0] now);
        item_t it;
        it = '0;
        it.operation = OP_REQUEST;
        it.focus_mode = mode;
        it.trigger = trig;
        it.now_us = now;
        return it;
    endfunction

    function automatic item_t make_report(input logic [2:0] status, input logic lens,
                                          input logic [TIME_W-1:0] now);
        item_t it;
        it = '0;
        it.operation = OP_REPORT;
        it.engine_status = status;
        it.lens_moving = lens;
        it.now_us = now;
        return it;
    endfunction

    // Frame clock: mostly one frame step, sometimes a long pause, a repeat or a jump
    function automatic logic [TIME_W-1:0] next_now();
        int unsigned pick;
        pick = $urandom_range(0, 31);
        if (pick == 0)
            clock_us = {16'($urandom), $urandom};
        else if (pick < 4)
            clock_us = clock_us + 48'($urandom_range(1, 16 * frame_step));
        else if (pick > 5)
            clock_us = clock_us + 48'($urandom_range(1, frame_step));
        return clock_us;
    endfunction

    // One input transaction, with an occasional idle burst before it
    task automatic feed_tracker(input item_t it);
        if (idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.operation;
        s_axis_tdata  <= {7'd0, it.now_us, it.lens_moving, it.engine_status,
                          it.focus_mode, it.trigger};
        do
            @(posedge clk);
        while (!s_axis_tready);
        track_focus(it);
    endtask

    // Let every outstanding result drain, plus the pipeline depth
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all timeout registers back to back, then the unused index
    task automatic program_timeouts(input logic [TOUT_W-1:0] t_max,
                                    input logic [TOUT_W-1:0] t_min,
                                    input logic [FRAME_W-1:0] frames);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_MAX_TIMEOUT;
        cfg_data  <= t_max;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_MIN_TIMEOUT;
        cfg_data  <= t_min;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_FRAME_LIMIT;
        cfg_data  <= {14'd0, frames};
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_SPARE;
        cfg_data  <= 24'($urandom);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        lim_max = t_max;
        lim_min = t_min;
        lim_frames = frames;
    endtask

    // Trigger sequences with random reports, mixed with raw noise transactions
    task automatic run_focus_sweeps(input int n_items, input int unsigned step_max);
        int          sent;
        int          n_rep;
        int unsigned p;
        logic [2:0]  mode;
        logic [2:0]  status;
        logic [63:0] raw;
        sent = 0;
        frame_step = step_max;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                raw = {$urandom, $urandom};
                feed_tracker(raw[57:0]);
                sent++;
            end
            else
            begin
                mode = 3'($urandom_range(0, 7));
                feed_tracker(make_request(mode, ($urandom_range(0, 3) == 0) ?
                                          2'($urandom_range(0, 3)) : TRIG_START, next_now()));
                sent++;
                n_rep = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) :
                                                     $urandom_range(20, 90);
                for (int k = 0; k < n_rep && sent < n_items; k++)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        if ($urandom_range(0, 3) == 0)
                            mode = 3'($urandom_range(0, 7));
                        feed_tracker(make_request(mode, 2'($urandom_range(0, 3)), next_now()));
                    end
                    else
                    begin
                        p = $urandom_range(0, 15);
                        if (p < 9)
                            status = ($urandom_range(0, 1) != 0) ? ENG_LOCAL : ENG_EXTENDED;
                        else if (p < 11)
                            status = ENG_SUCCESS;
                        else if (p < 12)
                            status = ENG_FAIL;
                        else
                            status = 3'($urandom_range(0, 7));
                        feed_tracker(make_report(status, 1'($urandom_range(0, 1)), next_now()));
                    end
                    sent++;
                end
            end
        end
    endtask

    // Hand-picked cases at the reset timeouts
    task automatic test_directed_cases();
        feed_tracker(make_report(ENG_QUIET, 1'b0, 48'd100));
        feed_tracker(make_request(MODE_AUTO, TRIG_START, 48'd1000));
        feed_tracker(make_report(ENG_LOCAL, 1'b1, 48'd2000));
        feed_tracker(make_report(ENG_SUCCESS, 1'b0, 48'd3000));
        // arming at time zero leaves the bank disarmed
        feed_tracker(make_request(MODE_AUTO, TRIG_START, 48'd0));
        feed_tracker(make_report(ENG_SUCCESS, 1'b1, 48'hFFFF_FFFF_FFFF));
        // elapsed time across the wrap of the time base
        feed_tracker(make_request(MODE_AUTO, TRIG_START, 48'hFFFF_FFFF_FF00));
        feed_tracker(make_report(ENG_EXTENDED, 1'b0, 48'd16));
        feed_tracker(make_report(ENG_QUIET, 1'b0, 48'd4_000_300));
        // alias mode and trigger three
        feed_tracker(make_request(MODE_ALIAS, TRIG_ALIAS, 48'd5_000_000));
        feed_tracker(make_report(ENG_FAIL, 1'b1, 48'd5_000_100));
        // continuous: focused survives cancel and later verdicts
        feed_tracker(make_request(MODE_CPIC, TRIG_START, 48'd6_000_000));
        feed_tracker(make_report(ENG_EXTENDED, 1'b1, 48'd6_033_000));
        feed_tracker(make_report(ENG_SUCCESS, 1'b0, 48'd6_066_000));
        feed_tracker(make_request(MODE_CPIC, TRIG_CANCEL, 48'd6_100_000));
        feed_tracker(make_report(ENG_FAIL, 1'b0, 48'd6_133_000));
        // mode change resets the continuous bank, then a time timeout
        feed_tracker(make_request(MODE_CVID, TRIG_IDLE, 48'd7_000_000));
        feed_tracker(make_report(ENG_ALIAS, 1'b1, 48'd7_033_000));
        feed_tracker(make_request(MODE_CVID, TRIG_START, 48'd8_000_000));
        feed_tracker(make_report(ENG_QUIET, 1'b0, 48'd12_000_001));
        feed_tracker(make_request(MODE_CVID, TRIG_CANCEL, 48'd12_100_000));
        // off mode always idle
        feed_tracker(make_request(MODE_OFF, TRIG_START, 48'd13_000_000));
        feed_tracker(make_report(ENG_LOCAL, 1'b1, 48'd13_033_000));
        feed_tracker(make_request(MODE_MACRO, TRIG_CANCEL, 48'd14_000_000));
        feed_tracker(make_report(ENG_TOP, 1'b1, 48'd14_033_000));
    endtask

    // Frame limit path on both banks
    task automatic test_frame_timeout();
        program_timeouts(24'hFF_FFFF, 24'd100, 10'd2);
        feed_tracker(make_request(MODE_AUTO, TRIG_START, 48'd1000));
        feed_tracker(make_report(ENG_LOCAL, 1'b0, 48'd1050));
        feed_tracker(make_report(ENG_LOCAL, 1'b1, 48'd1060));
        feed_tracker(make_report(ENG_QUIET, 1'b0, 48'd1200));
        feed_tracker(make_request(MODE_CVID, TRIG_START, 48'd5000));
        feed_tracker(make_report(ENG_LOCAL, 1'b1, 48'd5010));
        feed_tracker(make_report(ENG_EXTENDED, 1'b0, 48'd5020));
        feed_tracker(make_report(ENG_LOCAL, 1'b1, 48'd5300));
    endtask

    task automatic test_default_timeouts();
        program_timeouts(MAX_TIMEOUT_RST, MIN_TIMEOUT_RST, FRAME_LIMIT_RST);
        run_focus_sweeps(150, 60000);
    endtask

    task automatic test_zero_timeouts();
        program_timeouts(24'd0, 24'd0, 10'd0);
        run_focus_sweeps(80, 1000);
    endtask

    task automatic test_max_timeouts();
        program_timeouts(24'hFF_FFFF, 24'hFF_FFFF, FRAME_MAX);
        run_focus_sweeps(100, 3_000_000);
    endtask

    task automatic test_mid_timeouts();
        logic [TOUT_W-1:0] t_max;
        t_max = 24'($urandom_range(1000, 400000));
        program_timeouts(t_max, 24'($urandom_range(0, t_max)), 10'($urandom_range(0, 40)));
        run_focus_sweeps(150, t_max / 12 + 1);
    endtask

    // Back-to-back transactions, no idling on either side
    task automatic test_steady_stream();
        logic [TOUT_W-1:0] t_max;
        idle_en = 1'b0;
        t_max = 24'($urandom_range(1000, 400000));
        program_timeouts(t_max, 24'($urandom_range(0, t_max)), 10'($urandom_range(0, 40)));
        run_focus_sweeps(150, t_max / 12 + 1);
    endtask

    task automatic compare_field(input string name, input logic [2:0] want,
                                 input logic [2:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // Result side: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (reports_due.size() == 0)
            begin
                $error("result %h with none outstanding", m_axis_tdata);
                errors++;
            end
            else
            begin
                due = reports_due.pop_front();
                compare_field("mode_out", due.mode_out, m_axis_tdata[2:0]);
                compare_field("trigger_out", {1'b0, due.trigger_out}, {1'b0, m_axis_tdata[4:3]});
                compare_field("focus_state", {1'b0, due.focus_state}, {1'b0, m_axis_tdata[6:5]});
                compare_field("lens_state", {2'b0, due.lens_state}, {2'b0, m_axis_tdata[7]});
            end
        end
    end

    initial
    begin
        lim_max = MAX_TIMEOUT_RST;
        lim_min = MIN_TIMEOUT_RST;
        lim_frames = FRAME_LIMIT_RST;
        af_state = ST_IDLE;
        cf_state = ST_SCANNING;
        af_armed_at = '0;
        cf_armed_at = '0;
        af_frames = '0;
        cf_frames = '0;
        cur_mode = MODE_AUTO;
        cur_trig = TRIG_IDLE;
        clock_us = 48'd20_000_000;
        frame_step = 60000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_frame_timeout();
        test_default_timeouts();
        test_zero_timeouts();
        test_max_timeouts();
        test_mid_timeouts();
        test_steady_stream();
        settle();
        if (errors == 0)
            $display("PASS autofocus_state_tracker_top");
        else
            $display("FAIL autofocus_state_tracker_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("FAIL autofocus_state_tracker_top");
        $finish;
    end

endmodule

// File: files.f
src/aft_pkg.sv
src/aft_core.sv
src/autofocus_state_tracker_top.sv
src/aft_checker.sv
tb/autofocus_state_tracker_top_test.sv
